/* design/dffc_pkg.sv */
// ----------------------------------------------------------------------------
// dffc_pkg: shared types and constants
// Entry layout, store port structs and fixed field widths for the cache.
// ----------------------------------------------------------------------------
package dffc_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int BYTE_W  = 8;
  localparam int SEQ_W   = 12;
  localparam int KEY_W   = 4 * BYTE_W + SEQ_W;
  localparam int STAMP_W = 32;

  localparam logic [STAMP_W-1:0] TTL_RESET = 32'd5000;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [SEQ_W-1:0]   seq_t;

  // one remembered frame
  typedef struct packed {
    key_t   key;
    stamp_t stamp;
  } entry_t;

  // store write port
  typedef struct packed {
    logic   en;
    idx_t   addr;
    entry_t data;
  } wr_t;

  // shared compare unit result
  typedef struct packed {
    logic expired;
    logic hit;
  } chk_t;

endpackage

/* design/dffc_if.sv */
// ----------------------------------------------------------------------------
// dffc channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dffc_req_if;
  import dffc_pkg::*;

  logic   valid;
  logic   ready;
  logic   mode;
  byte_t  source_addr;
  byte_t  dest_addr;
  byte_t  command;
  byte_t  flag_bits;
  seq_t   sequence_req;
  stamp_t time_now;

  modport source (
    output valid, mode, source_addr, dest_addr, command, flag_bits, sequence_req, time_now,
    input  ready
  );
  modport sink (
    input  valid, mode, source_addr, dest_addr, command, flag_bits, sequence_req, time_now,
    output ready
  );
endinterface

interface dffc_rsp_if;
  logic valid;
  logic ready;
  logic is_duplicate;

  modport source (output valid, is_duplicate, input ready);
  modport sink (input valid, is_duplicate, output ready);
endinterface

interface dffc_cfg_if;
  import dffc_pkg::*;

  logic   valid;
  logic   ready;
  stamp_t ttl_ms;

  modport source (output valid, ttl_ms, input ready);
  modport sink (input valid, ttl_ms, output ready);
endinterface

/* design/duplicate_frame_filter_cache_core.sv */
// ----------------------------------------------------------------------------
// duplicate_frame_filter_cache_core: duplicate frame filter cache
// Sequence: idle takes a request; the scan stops at a duplicate, a miss
//   fills a slot in insert, a clear goes straight to done, and done registers
//   the answer once the output register is free. The scan visits one entry a
//   cycle through the shared compare unit; a new request waits for idle.
// Reset clears all valid marks, the replace pointer and sets ttl_ms to 5000.
// ----------------------------------------------------------------------------
module duplicate_frame_filter_cache_core (
  input logic      clk,
  input logic      rst,
  dffc_req_if.sink req,
  dffc_rsp_if.source rsp,
  dffc_cfg_if.sink cfg
);
  import dffc_pkg::*;

  localparam idx_t LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_INSERT, S_DONE} state_t;

  state_t               state;
  logic [ENTRIES-1:0]   entry_valid;
  idx_t                 replace_ptr;
  stamp_t               ttl;
  key_t                 key_r;
  stamp_t               now_r;
  idx_t                 scan_idx;
  logic                 free_found;
  idx_t                 free_idx;
  logic                 dup_r;
  logic                 rsp_valid;
  logic                 rsp_dup;

  idx_t   rd_addr;
  entry_t rd_data;
  wr_t    wr;
  chk_t   chk;
  logic   last_idx;
  logic   slot_free;
  logic   hit;

  dffc_entry_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dffc_age_match u_cmp (
    .entry (rd_data),
    .key   (key_r),
    .now   (now_r),
    .ttl   (ttl),
    .chk   (chk)
  );

  // scan decode for the entry whose data is on the read port
  assign last_idx  = (scan_idx == LAST_IDX);
  assign slot_free = !entry_valid[scan_idx] || chk.expired;
  assign hit       = entry_valid[scan_idx] && !chk.expired && chk.hit;

  // prefetch the next entry while checking this one
  always_comb begin
    rd_addr = '0;
    if (state == S_SCAN && !last_idx) begin
      rd_addr = scan_idx + 1'b1;
    end
  end

  // store writes: refresh on hit, fill on miss
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = scan_idx;
    wr.data = '{key: key_r, stamp: now_r};
    if (state == S_SCAN && hit) begin
      wr.en = 1'b1;
    end else if (state == S_INSERT) begin
      wr.en   = 1'b1;
      wr.addr = free_found ? free_idx : replace_ptr;
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign cfg.ready        = 1'b1;
  assign rsp.valid        = rsp_valid;
  assign rsp.is_duplicate = rsp_dup;

  // sequencer, valid marks and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      replace_ptr <= '0;
      ttl         <= TTL_RESET;
      free_found  <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        ttl <= cfg.ttl_ms;
      end
      // S_DONE handles the output register itself
      if (rsp_valid && rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            key_r      <= {req.source_addr, req.dest_addr, req.command,
                           req.flag_bits, req.sequence_req};
            now_r      <= req.time_now;
            scan_idx   <= '0;
            free_found <= 1'b0;
            if (req.mode) begin
              entry_valid <= '0;
              replace_ptr <= '0;
              dup_r       <= 1'b0;
              state       <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (entry_valid[scan_idx] && chk.expired) begin
            entry_valid[scan_idx] <= 1'b0;
          end
          if (hit) begin
            dup_r <= 1'b1;
            state <= S_DONE;
          end else begin
            if (slot_free && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= scan_idx;
            end
            if (last_idx) begin
              state <= S_INSERT;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
        end

        S_INSERT: begin
          entry_valid[wr.addr] <= 1'b1;
          replace_ptr          <= (wr.addr == LAST_IDX) ? '0 : wr.addr + 1'b1;
          dup_r                <= 1'b0;
          state                <= S_DONE;
        end

        S_DONE: begin
          // wait for the output register to free up
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_dup   <= dup_r;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // clear request drops every entry and the pointer
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.mode) |=> (entry_valid == '0 && replace_ptr == '0))
    else $error("clear request left live entries");

  // pointer stays inside the table
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    replace_ptr <= LAST_IDX)
    else $error("replace pointer out of range");

  // a filled slot is marked live
  a_insert_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSERT) |=> entry_valid[$past(wr.addr)])
    else $error("inserted entry not marked valid");

endmodule

/* design/dffc_entry_store.sv */
// ----------------------------------------------------------------------------
// dffc_entry_store: key and timestamp memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dffc_entry_store (
  input  logic            clk,
  input  dffc_pkg::wr_t   wr,
  input  dffc_pkg::idx_t  rd_addr,
  output dffc_pkg::entry_t rd_data
);
  import dffc_pkg::*;

  entry_t mem [ENTRIES];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/dffc_age_match.sv */
// ----------------------------------------------------------------------------
// dffc_age_match: shared age and key compare unit
// Checks one entry against the request: expiry against TTL and key equality.
// ----------------------------------------------------------------------------
module dffc_age_match (
  input  dffc_pkg::entry_t entry,
  input  dffc_pkg::key_t   key,
  input  dffc_pkg::stamp_t now,
  input  dffc_pkg::stamp_t ttl,
  output dffc_pkg::chk_t   chk
);
  import dffc_pkg::*;

  stamp_t age;

  // a wrapped clock (now below last seen) never expires an entry
  assign age         = now - entry.stamp;
  assign chk.expired = (now >= entry.stamp) && (age > ttl);
  assign chk.hit     = (entry.key == key);

endmodule
